/* design/ctc_pkg.sv */
// Package: shared types, character codes and the connective decision function.
`timescale 1ns / 1ps
package ctc_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_SPACE  = " ";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_LBRACK = "[";
  localparam logic [7:0] CH_RBRACK = "]";
  localparam logic [7:0] CH_LBRACE = "{";
  localparam logic [7:0] CH_RBRACE = "}";
  localparam logic [7:0] CH_LT     = "<";
  localparam logic [7:0] CH_GT     = ">";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_APOS   = "'";
  localparam logic [7:0] CH_DQUOTE = "\"";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_EQ     = "=";
  localparam logic [7:0] CH_AMP    = "&";
  localparam logic [7:0] CH_PIPE   = "|";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_BSLASH = "\\";
  localparam logic [7:0] CH_ONE    = "1";
  localparam logic [7:0] CH_TWO    = "2";
  localparam logic [7:0] CH_COLON  = ":";
  localparam logic [7:0] CH_DOLLAR = "$";
  localparam logic [7:0] CH_QMARK  = "?";
  localparam logic [7:0] CH_CARET  = "^";
  localparam logic [7:0] CH_BANG   = "!";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_SEMI   = ";";
  localparam logic [7:0] CH_UNDER  = "_";
  localparam logic [7:0] CH_PCT    = "%";
  localparam logic [7:0] CH_HASH   = "#";

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       end_mark;
  } out_t;

  // Plain: one character. Pad: space, char, space. Open quote: space, (, space, quote, space.
  typedef enum logic [1:0] {
    TK_PLAIN,
    TK_PAD,
    TK_OPEN_Q
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] ch;
    logic       last;
  } tok_t;

  typedef struct packed {
    logic [1:0] k;
    tok_t       tok;
  } dec_t;

  // One decision on the head of the window. k is the number of bytes consumed,
  // zero when the rule cannot be settled yet.
  function automatic dec_t ctc_decide(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                      logic [1:0] avail, logic fin);
    dec_t res;
    logic done;
    res.k        = 2'd1;
    res.tok.kind = TK_PLAIN;
    res.tok.ch   = c0;
    res.tok.last = 1'b0;
    done         = 1'b0;
    case (c0)
      CH_COMMA: begin
        res.tok.ch = CH_SPACE;
        done = 1'b1;
      end
      CH_LBRACK: begin
        res.tok.kind = TK_OPEN_Q;
        res.tok.ch   = CH_APOS;
        done = 1'b1;
      end
      CH_LBRACE: begin
        res.tok.kind = TK_OPEN_Q;
        res.tok.ch   = CH_DQUOTE;
        done = 1'b1;
      end
      CH_RBRACE, CH_RBRACK, CH_GT: begin
        res.tok.ch = CH_RPAREN;
        done = 1'b1;
      end
      default: begin
      end
    endcase
    if (!done && c0 == CH_LT) begin
      if (avail >= 2'd2) begin
        if (c1 != CH_MINUS && c1 != CH_EQ) begin
          res.tok.ch = CH_LPAREN;
          done = 1'b1;
        end
      end else if (fin) begin
        res.tok.ch = CH_LPAREN;
        done = 1'b1;
      end else begin
        res.k = 2'd0;
        done = 1'b1;
      end
    end
    if (!done && !fin && avail < 2'd3) begin
      res.k = 2'd0;
      done = 1'b1;
    end
    if (!done && avail >= 2'd2) begin
      done = 1'b1;
      res.k = 2'd2;
      if (c0 == CH_AMP && c1 == CH_SLASH)         res.tok.ch = CH_PLUS;
      else if (c0 == CH_AMP && c1 == CH_AMP)      res.tok.ch = CH_SEMI;
      else if (c0 == CH_PIPE && c1 == CH_PIPE)    res.tok.ch = CH_UNDER;
      else if (c0 == CH_SLASH && c1 == CH_ONE)    res.tok.ch = CH_SLASH;
      else if (c0 == CH_SLASH && c1 == CH_TWO)    res.tok.ch = CH_PCT;
      else if (c0 == CH_BSLASH && c1 == CH_ONE)   res.tok.ch = CH_BSLASH;
      else if (c0 == CH_BSLASH && c1 == CH_TWO)   res.tok.ch = CH_HASH;
      else if (avail == 2'd3) begin
        res.k = 2'd3;
        if (c0 == CH_MINUS && c1 == CH_MINUS && c2 == CH_GT)      res.tok.ch = CH_COLON;
        else if (c0 == CH_PIPE && c1 == CH_MINUS && c2 == CH_GT)  res.tok.ch = CH_COMMA;
        else if (c0 == CH_LT && c1 == CH_MINUS && c2 == CH_GT)    res.tok.ch = CH_EQ;
        else if (c0 == CH_EQ && c1 == CH_SLASH && c2 == CH_GT)    res.tok.ch = CH_DOLLAR;
        else if (c0 == CH_EQ && c1 == CH_EQ && c2 == CH_GT)       res.tok.ch = CH_QMARK;
        else if (c0 == CH_LT && c1 == CH_EQ && c2 == CH_GT)       res.tok.ch = CH_CARET;
        else if (c0 == CH_MINUS && c1 == CH_MINUS) begin
          res.k = 2'd2;
          res.tok.ch = CH_BANG;
        end else begin
          res.k = 2'd1;
        end
      end else begin
        res.k = 2'd1;
      end
    end
    // Any parenthesis that comes out, passed through or produced, is padded.
    if (res.tok.kind == TK_PLAIN && (res.tok.ch == CH_LPAREN || res.tok.ch == CH_RPAREN)) begin
      res.tok.kind = TK_PAD;
    end
    return res;
  endfunction

endpackage

/* design/ctc_front.sv */
// Front end: fills a three-byte window; decides one connective per cycle while queue has room.
`timescale 1ns / 1ps
module ctc_front
  import ctc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  in_t  in_data,
  output logic q_push,
  output tok_t q_data,
  input  logic q_full
);

  logic [7:0] w_r [3];
  logic [7:0] w_nxt [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic       fin_r, fin_nxt;
  logic       busy_r, busy_nxt;

  dec_t       dec;
  logic [1:0] rem;
  logic       step_go;
  logic       loop_done;
  logic       accept;

  always_comb begin
    dec       = ctc_decide(w_r[0], w_r[1], w_r[2], cnt_r, fin_r);
    rem       = cnt_r - dec.k;
    step_go   = busy_r && (dec.k != 2'd0) && !q_full;
    loop_done = busy_r && ((dec.k == 2'd0) || (step_go && rem == 2'd0));
    in_full   = busy_r && !loop_done;
    accept    = in_push && !in_full;

    q_push        = step_go;
    q_data        = dec.tok;
    q_data.last   = fin_r && (rem == 2'd0);

    w_nxt    = w_r;
    cnt_nxt  = cnt_r;
    fin_nxt  = fin_r;
    busy_nxt = busy_r;

    if (step_go) begin
      case (dec.k)
        2'd1: begin
          w_nxt[0] = w_r[1];
          w_nxt[1] = w_r[2];
        end
        2'd2: w_nxt[0] = w_r[2];
        default: begin
        end
      endcase
      cnt_nxt = rem;
      if (rem == 2'd0) begin
        fin_nxt = 1'b0;
      end
    end
    if (loop_done) begin
      busy_nxt = 1'b0;
    end
    if (accept) begin
      case (cnt_nxt)
        2'd0:    w_nxt[0] = in_data.in_byte;
        2'd1:    w_nxt[1] = in_data.in_byte;
        default: w_nxt[2] = in_data.in_byte;
      endcase
      cnt_nxt  = cnt_nxt + 2'd1;
      fin_nxt  = in_data.is_final;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r[0] <= '0;
      w_r[1] <= '0;
      w_r[2] <= '0;
      cnt_r  <= '0;
      fin_r  <= 1'b0;
      busy_r <= 1'b0;
    end else begin
      w_r    <= w_nxt;
      cnt_r  <= cnt_nxt;
      fin_r  <= fin_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

/* design/ctc_fifo.sv */
// Token queue between the front end and the back end.
`timescale 1ns / 1ps
module ctc_fifo
  import ctc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tok_t push_data,
  output logic full,
  input  logic pop,
  output tok_t pop_data,
  output logic empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

/* design/ctc_back.sv */
// Back end: expands tokens into characters, padded as the kind asks; one character per cycle unless output is held.
`timescale 1ns / 1ps
module ctc_back
  import ctc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  output logic q_pop,
  input  tok_t q_data,
  input  logic q_empty,
  output logic out_empty,
  input  logic out_pop,
  output out_t out_data
);

  tok_t       tok_r;
  logic       tok_valid_r;
  logic [2:0] idx_r;
  out_t       out_r;
  logic       out_valid_r;

  logic [2:0] last_idx;
  logic [7:0] cur_char;
  logic       last_char;
  logic       load;
  logic       take;

  always_comb begin
    case (tok_r.kind)
      TK_PLAIN: begin
        last_idx = 3'd0;
        cur_char = tok_r.ch;
      end
      TK_PAD: begin
        last_idx = 3'd2;
        cur_char = (idx_r == 3'd1) ? tok_r.ch : CH_SPACE;
      end
      TK_OPEN_Q: begin
        last_idx = 3'd4;
        if (idx_r == 3'd1)      cur_char = CH_LPAREN;
        else if (idx_r == 3'd3) cur_char = tok_r.ch;
        else                    cur_char = CH_SPACE;
      end
      default: begin
        last_idx = 3'd0;
        cur_char = tok_r.ch;
      end
    endcase
    last_char = (idx_r == last_idx);
    load      = tok_valid_r && (!out_valid_r || out_pop);
    take      = !tok_valid_r || (load && last_char);
    q_pop     = take && !q_empty;
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.out_char <= cur_char;
      out_r.end_mark <= tok_r.last && last_char;
    end
    if (q_pop) begin
      tok_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        tok_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (load && last_char) begin
        tok_valid_r <= 1'b0;
      end else if (load) begin
        idx_r <= idx_r + 3'd1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* design/copula_token_canonicalizer_top.sv */
// Top level of the connective canonicalizer: front end, token queue and back end.
`timescale 1ns / 1ps
// The block takes statement text one byte per item, with is_final set on the
// last byte, and returns the canonical text one character per item, with
// end_mark set on the last character of the statement. The front end keeps a
// window of up to three bytes and settles one connective per cycle while the
// queue has room; a byte is accepted in the cycle after the previous one when
// its rule settles at once, and in steady text each byte first enters the
// window and is then decided at its head. Settled tokens wait in a small queue
// of QUEUE_DEPTH entries. The back end writes one character per cycle into the
// output register while it is empty or being popped, so a plain token gives one
// character, a padded parenthesis three and an opening bracket or brace five.
// The output register is refilled as its character is popped, and a full queue
// stalls only the front end. There are no configuration registers and no
// start-up sweep: the block takes items from the first cycle after reset.
module copula_token_canonicalizer_top
  import ctc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  in_t  in_data,
  output logic out_empty,
  input  logic out_pop,
  output out_t out_data
);

  // Token queue handshake between the two halves.
  logic q_push, q_full, q_pop, q_empty;
  tok_t q_wdata, q_rdata;

  ctc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  ctc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  ctc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .q_empty   (q_empty),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // The front end must never push a token that the queue would drop.
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("token pushed into a full queue");

  // The back end must never take a token from an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("token popped from an empty queue");

  // A token pushed into an empty queue is visible to the back end next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) (q_push && q_empty) |=> !q_empty)
    else $error("token lost in the queue");

endmodule

/* sim/tb_copula_token_canonicalizer_top.sv */
// Testbench for the connective canonicalizer: random statements against a scoreboard.
`timescale 1ns / 1ps
// Statements are pushed one byte per item, with is_final set on the last byte of
// each. For every accepted byte the scoreboard works out which characters the
// byte releases, using its own copy of the lookahead window. Each popped
// character is checked in order against the oldest expected one. Both sides
// idle at random, with stretches of back-to-back traffic. A watchdog ends the
// run when nothing moves on either side for too long.
module tb_copula_token_canonicalizer_top;
  import ctc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_GAP     = 17;
  localparam int ITEM_GOAL   = 200;

  // The scoreboard holds the predicted text and the window of bytes whose rule
  // is not settled yet.
  class canon_scoreboard;
    out_t        expected_chars[$];
    logic [7:0]  held_bytes[2];
    int unsigned held_count;
    out_t        step_buf[12];
    int          step_len;
    int          mismatches;

    function new();
      held_bytes[0] = 8'h00;
      held_bytes[1] = 8'h00;
      held_count    = 0;
      mismatches    = 0;
    endfunction

    function int outstanding();
      return expected_chars.size();
    endfunction

    function void push_char(logic [7:0] c);
      if (step_len < 12) begin
        step_buf[step_len] = '{out_char: c, end_mark: 1'b0};
        step_len++;
      end
    endfunction

    // Parentheses always come out with a space on each side.
    function void put_token(logic [7:0] c);
      if (c == CH_LPAREN || c == CH_RPAREN) begin
        push_char(CH_SPACE);
        push_char(c);
        push_char(CH_SPACE);
      end else begin
        push_char(c);
      end
    endfunction

    // Settles the rule at the head of the window. Returns the number of bytes
    // consumed, or zero while more bytes are needed.
    function int unsigned settle_head(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                      int unsigned avail, bit fin);
      if (c0 == CH_COMMA) begin
        put_token(CH_SPACE);
        return 1;
      end
      if (c0 == CH_LBRACK || c0 == CH_LBRACE) begin
        put_token(CH_LPAREN);
        put_token(c0 == CH_LBRACK ? CH_APOS : CH_DQUOTE);
        put_token(CH_SPACE);
        return 1;
      end
      if (c0 == CH_RBRACE || c0 == CH_RBRACK || c0 == CH_GT) begin
        put_token(CH_RPAREN);
        return 1;
      end
      if (c0 == CH_LT) begin
        if (avail >= 2) begin
          if (c1 != CH_MINUS && c1 != CH_EQ) begin
            put_token(CH_LPAREN);
            return 1;
          end
        end else if (fin) begin
          put_token(CH_LPAREN);
          return 1;
        end else begin
          return 0;
        end
      end
      if (!fin && avail < 3) return 0;
      if (avail >= 2) begin
        if (c0 == CH_AMP && c1 == CH_SLASH) begin
          put_token(CH_PLUS);
          return 2;
        end
        if (c0 == CH_AMP && c1 == CH_AMP) begin
          put_token(CH_SEMI);
          return 2;
        end
        if (c0 == CH_PIPE && c1 == CH_PIPE) begin
          put_token(CH_UNDER);
          return 2;
        end
        if (c0 == CH_SLASH && c1 == CH_ONE) begin
          put_token(CH_SLASH);
          return 2;
        end
        if (c0 == CH_SLASH && c1 == CH_TWO) begin
          put_token(CH_PCT);
          return 2;
        end
        if (c0 == CH_BSLASH && c1 == CH_ONE) begin
          put_token(CH_BSLASH);
          return 2;
        end
        if (c0 == CH_BSLASH && c1 == CH_TWO) begin
          put_token(CH_HASH);
          return 2;
        end
        if (avail >= 3) begin
          if (c0 == CH_MINUS && c1 == CH_MINUS && c2 == CH_GT) begin
            put_token(CH_COLON);
            return 3;
          end
          if (c0 == CH_PIPE && c1 == CH_MINUS && c2 == CH_GT) begin
            put_token(CH_COMMA);
            return 3;
          end
          if (c0 == CH_LT && c1 == CH_MINUS && c2 == CH_GT) begin
            put_token(CH_EQ);
            return 3;
          end
          if (c0 == CH_EQ && c1 == CH_SLASH && c2 == CH_GT) begin
            put_token(CH_DOLLAR);
            return 3;
          end
          if (c0 == CH_EQ && c1 == CH_EQ && c2 == CH_GT) begin
            put_token(CH_QMARK);
            return 3;
          end
          if (c0 == CH_LT && c1 == CH_EQ && c2 == CH_GT) begin
            put_token(CH_CARET);
            return 3;
          end
          if (c0 == CH_MINUS && c1 == CH_MINUS) begin
            put_token(CH_BANG);
            return 2;
          end
        end
      end
      put_token(c0);
      return 1;
    endfunction

    function void note_byte(in_t it);
      logic [7:0]  win[3];
      int unsigned fill;
      int unsigned used;
      int unsigned i;
      win[0] = held_bytes[0];
      win[1] = held_bytes[1];
      win[2] = 8'h00;
      win[held_count] = it.in_byte;
      fill = held_count + 1;
      step_len = 0;
      while (fill > 0) begin
        used = settle_head(win[0], win[1], win[2], fill, it.is_final);
        if (used == 0) break;
        for (i = 0; i < 3; i++) begin
          if (i + used < 3) win[i] = win[i + used];
          else win[i] = 8'h00;
        end
        fill -= used;
      end
      if (it.is_final) begin
        if (step_len > 0) step_buf[step_len - 1].end_mark = 1'b1;
        fill = 0;
      end
      for (i = 0; i < step_len; i++) expected_chars.push_back(step_buf[i]);
      held_count    = fill;
      held_bytes[0] = (fill >= 1) ? win[0] : 8'h00;
      held_bytes[1] = (fill >= 2) ? win[1] : 8'h00;
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual char %h end_mark %b",
                 $time, got.out_char, got.end_mark);
        mismatches++;
        return;
      end
      want = expected_chars.pop_front();
      if (got.out_char !== want.out_char) begin
        $display("%0t: out_char mismatch: expected %h, actual %h",
                 $time, want.out_char, got.out_char);
        mismatches++;
      end
      if (got.end_mark !== want.end_mark) begin
        $display("%0t: end_mark mismatch: expected %b, actual %b",
                 $time, want.end_mark, got.end_mark);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_push;
  logic in_full;
  in_t  in_data;
  logic out_empty;
  logic out_pop;
  out_t out_data;

  canon_scoreboard sb = new();

  // Bytes of the statement being built; the last one goes out with is_final.
  logic [7:0] stmt_bytes[$];
  int         items_sent;
  bit         sender_quiet;
  bit         drain_done;
  bit         sink_quiet;
  int         stall_cycles;

  // Whole connectives, lone openers and closers, plus a few broken prefixes
  // so that near misses show up inside otherwise well-formed text.
  string fragments[25] = '{"-->", "|->", "<->", "=/>", "==>", "<=>", "--", "&/", "&&",
                           "||", "/1", "/2", "\\1", "\\2", "[", "{", "}", "]", ">", "<",
                           ",", "-", "=", "<-", "<="};

  copula_token_canonicalizer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // Pushes one byte. The push line is only lowered when a gap is drawn, so a
  // back-to-back item keeps it high without a second assignment in the step.
  task automatic send_byte(logic [7:0] b, bit fin);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{in_byte: b, is_final: fin};
    do @(posedge clk); while (in_full);
    sb.note_byte('{in_byte: b, is_final: fin});
    items_sent++;
  endtask

  task automatic add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) stmt_bytes.push_back(s.getc(i));
  endtask

  task automatic flush_statement();
    int i;
    for (i = 0; i < stmt_bytes.size(); i++) send_byte(stmt_bytes[i], i == stmt_bytes.size() - 1);
    stmt_bytes.delete();
  endtask

  // Mostly letters and connectives, with a share of arbitrary bytes as noise.
  task automatic build_random_statement();
    int parts;
    int p;
    int pick;
    parts = $urandom_range(1, 12);
    for (p = 0; p < parts; p++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) add_text(fragments[$urandom_range(0, 24)]);
      else if (pick < 85) stmt_bytes.push_back(8'($urandom_range("a", "z")));
      else stmt_bytes.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_data      = '0;
    items_sent   = 0;
    sender_quiet = 1'b0;
    drain_done   = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. First: an opening bracket, a comma, the byte extremes,
    // a zero byte, a closing brace and a lone < as the last byte.
    add_text("[,");
    stmt_bytes.push_back(8'h01);
    stmt_bytes.push_back(8'hFF);
    stmt_bytes.push_back(8'h00);
    add_text("}<");
    flush_statement();
    // An opening brace, then four of the three-byte connectives.
    add_text("{-->|-><->=/>");
    flush_statement();
    // The remaining three-byte ones, then a short tail where "<-" cannot match.
    add_text("==><=>]<-");
    flush_statement();
    // A final "--" is too short for the double-dash rule.
    add_text("--");
    flush_statement();

    // Random part. Partway through, the sender holds off until the block has
    // drained, so the window starts over from an empty pipeline.
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 3) == 0) sender_quiet = ~sender_quiet;
      if (!drain_done && items_sent >= ITEM_GOAL / 2) begin
        drain_done = 1'b1;
        if (sb.outstanding() != 0) begin
          in_push <= 1'b0;
          while (sb.outstanding() != 0) @(posedge clk);
        end
      end
      build_random_statement();
      flush_statement();
    end
    in_push <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb_copula_token_canonicalizer_top passed");
    end else begin
      $display("tb_copula_token_canonicalizer_top failed");
    end
    $finish;
  end

  // Result side: pops with random stalls, switching between stalling and
  // popping every cycle now and then.
  initial begin
    int gap;
    out_pop    = 1'b0;
    sink_quiet = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_quiet = ~sink_quiet;
      gap = sink_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      sb.check_result(out_data);
    end
  end

  // Counts cycles in which no item moves on either side.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_copula_token_canonicalizer_top failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
